FILE: rtl/flpk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flpk_pkg;

    localparam int LEN_W  = 14;
    localparam int BYTE_W = 8;
    localparam int STEP_W = 4;

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // header byte positions that depend on the length
    localparam logic [STEP_W-1:0] HDR_LEN_STEP    = 4'd7;
    localparam logic [STEP_W-1:0] HDR_LEN_LO_STEP = 4'd8;

    localparam logic [LEN_W-1:0] SHORT_LEN_MAX = 14'd63;

    localparam logic [BYTE_W-1:0] LEN_SHORT_TAG = 8'h80;
    localparam logic [BYTE_W-1:0] LEN_LONG_TAG  = 8'hC0;

    typedef struct packed {
        logic                  action;
        logic [LEN_W-1:0]      message_length;
        logic [BYTE_W-1:0]     data_byte;
    } t_item;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] out_byte;
        logic              frame_end;
        logic              message_end;
        logic              run_last;
    } t_beat;

    // Header byte for a given step of a start item.
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [STEP_W-1:0] step,
                                                   input logic [LEN_W-1:0]  len);
        logic [BYTE_W-1:0] b;
        b = 8'h00;
        case (step)
            4'd0: b = 8'hFF;
            4'd1: b = 8'h08;
            4'd2: b = 8'h00;
            4'd3: b = 8'h01;
            4'd4: b = 8'h01;
            4'd5: b = 8'h02;
            4'd6: b = 8'h01;
            4'd7: begin
                if (len > SHORT_LEN_MAX) begin
                    b = LEN_LONG_TAG | {2'b00, len[13:8]};
                end else begin
                    b = LEN_SHORT_TAG | len[7:0];
                end
            end
            4'd8: b = len[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/flpk_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Byte sequencer: one output beat per cycle while the output side is ready, from the held item and frame state.
module flpk_seq #(
    parameter int FRAME_BYTES = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_item_valid,
    input  wire flpk_pkg::t_item i_item,
    input  wire                 i_out_ready,
    output flpk_pkg::t_beat     o_beat,
    output logic                o_consume
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    logic [POS_W-1:0]                 r_frame_pos, n_frame_pos;
    logic [flpk_pkg::LEN_W-1:0]       r_remaining, n_remaining;
    logic                             r_open, n_open;
    logic [flpk_pkg::STEP_W-1:0]      r_step, n_step;
    logic                             r_pad, n_pad;

    logic [POS_W-1:0]                 pos_base;
    logic [POS_W-1:0]                 pos_next;
    logic                             wraps;
    logic [flpk_pkg::STEP_W-1:0]      hdr_last_step;
    logic [flpk_pkg::LEN_W-1:0]       rem_dec;
    logic                             done;
    logic                             advance;
    flpk_pkg::t_beat                  beat;

    always_comb begin
        pos_base = (i_item.action == flpk_pkg::ACT_START && r_step == '0 && !r_pad)
                   ? '0 : r_frame_pos;
        pos_next = (pos_base == POS_LAST) ? '0 : pos_base + 1'b1;
        wraps    = (pos_next == '0);
        hdr_last_step = (i_item.message_length > flpk_pkg::SHORT_LEN_MAX)
                        ? flpk_pkg::HDR_LEN_LO_STEP : flpk_pkg::HDR_LEN_STEP;
        rem_dec  = r_remaining - 1'b1;
    end

    always_comb begin
        beat        = '0;
        done        = 1'b0;
        n_remaining = r_remaining;
        n_open      = r_open;
        n_step      = r_step;
        n_pad       = r_pad;
        if (i_item_valid) begin
            if (r_pad) begin
                beat.valid     = 1'b1;
                beat.frame_end = wraps;
                if (wraps) begin
                    beat.message_end = 1'b1;
                    beat.run_last    = 1'b1;
                    done             = 1'b1;
                    n_open           = 1'b0;
                    n_remaining      = '0;
                end
            end else if (i_item.action == flpk_pkg::ACT_START) begin
                beat.valid     = 1'b1;
                beat.out_byte  = flpk_pkg::hdr_byte(r_step, i_item.message_length);
                beat.frame_end = wraps;
                if (r_step == hdr_last_step) begin
                    n_open      = 1'b1;
                    n_remaining = i_item.message_length;
                    if (i_item.message_length == '0) begin
                        n_pad = 1'b1;
                    end else begin
                        beat.run_last = 1'b1;
                        done          = 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end else if (r_open) begin
                beat.valid     = 1'b1;
                beat.out_byte  = i_item.data_byte;
                beat.frame_end = wraps;
                n_remaining    = rem_dec;
                if (rem_dec == '0) begin
                    n_open = 1'b0;
                    if (wraps) begin
                        beat.message_end = 1'b1;
                        beat.run_last    = 1'b1;
                        done             = 1'b1;
                    end else begin
                        n_pad = 1'b1;
                    end
                end else begin
                    beat.run_last = 1'b1;
                    done          = 1'b1;
                end
            end else begin
                // stray data byte: dropped, no beat
                done = 1'b1;
            end
        end
        n_frame_pos = beat.valid ? pos_next : r_frame_pos;
        if (done) begin
            n_step = '0;
            n_pad  = 1'b0;
        end
    end

    assign advance   = i_item_valid && (!beat.valid || i_out_ready);
    assign o_beat    = beat;
    assign o_consume = advance && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pos <= '0;
            r_remaining <= '0;
            r_open      <= 1'b0;
            r_step      <= '0;
            r_pad       <= 1'b0;
        end else if (advance) begin
            r_frame_pos <= n_frame_pos;
            r_remaining <= n_remaining;
            r_open      <= n_open;
            r_step      <= n_step;
            r_pad       <= n_pad;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/flpk_obuf.sv
`timescale 1ns / 1ps
`default_nettype none

// Output register: holds one beat until the sink takes it.
module flpk_obuf (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire flpk_pkg::t_beat i_beat,
    output logic                o_ready,
    output flpk_pkg::t_beat     o_beat,
    input  wire                 i_take
);

    logic            r_valid;
    flpk_pkg::t_beat r_beat;

    assign o_ready = !r_valid || i_take;

    always_comb begin
        o_beat       = r_beat;
        o_beat.valid = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_beat.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_beat.valid) begin
            r_beat <= i_beat;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/length_prefixed_frame_packer_unit.sv
// The first beat of an item passes the input register and then the output register before it is valid on m_axis.
// Throughput: one data item per cycle while the output is not stalled; the sequencer emits one byte per cycle, so a
// start item holds the input while its 8 or 9 header bytes are sent, and a message close adds padding bytes up to
// the frame end, up to FRAME_BYTES - 1 of them. A data byte with no open message is dropped with no beat.
// Reset: i_rst_n is synchronous, active low; clears valid flags and frame/message state.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_packer_unit #(
    parameter int FRAME_BYTES = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [13:0] message_length, [21:14] data_byte, [23:22] zero
    input  wire         s_axis_tuser,   // [0] action (0 start, 1 data)
    // output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // frame_end
    output logic [1:0]  m_axis_tuser    // [0] message_end, [1] run_last
);

    // Input register: one item held while the sequencer works through its bytes.
    logic            r_in_valid;
    flpk_pkg::t_item r_item;
    logic            consume;
    logic            obuf_ready;
    flpk_pkg::t_beat seq_beat;
    flpk_pkg::t_beat out_beat;

    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.action         <= s_axis_tuser;
            r_item.message_length <= s_axis_tdata[13:0];
            r_item.data_byte      <= s_axis_tdata[21:14];
        end
    end

    // Sequencer: header, payload and padding bytes, frame position tracking.
    flpk_seq #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (r_in_valid),
        .i_item       (r_item),
        .i_out_ready  (obuf_ready),
        .o_beat       (seq_beat),
        .o_consume    (consume)
    );

    // Output register holds each beat until the sink takes it; its ready follows the sink's tready combinationally.
    flpk_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (seq_beat),
        .o_ready (obuf_ready),
        .o_beat  (out_beat),
        .i_take  (m_axis_tready)
    );

    assign m_axis_tvalid   = out_beat.valid;
    assign m_axis_tdata    = out_beat.out_byte;
    assign m_axis_tlast    = out_beat.frame_end;
    assign m_axis_tuser[0] = out_beat.message_end;
    assign m_axis_tuser[1] = out_beat.run_last;

    // a message always closes on a frame boundary
    a_msg_end_on_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("message end off a frame boundary");

    // closing byte is the last beat of its item
    a_msg_end_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
        else $error("message end without run last");

    // input only stalls while an item is held
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with empty input register");

endmodule

`default_nettype wire
